[rtl/ptt_pkg.sv]
`default_nettype none

package ptt_pkg;

   // Table and ring sizes
   localparam int NODE_SLOTS = 64;
   localparam int RING_SLOTS = 128;
   localparam int NODE_W     = $clog2(NODE_SLOTS);
   localparam int SLOT_W     = 7;
   localparam int FLIGHT_W   = 8;
   localparam int COUNT_W    = 7;

   // Command codes
   localparam logic [1:0] CMD_REGISTER = 2'd0;
   localparam logic [1:0] CMD_DOORBELL = 2'd1;
   localparam logic [1:0] CMD_TRANSMIT = 2'd2;
   localparam logic [1:0] CMD_COMPLETE = 2'd3;

   // Doorbell words and unicast MAC prefix
   localparam logic [15:0] DB_JOIN    = 16'h1000;
   localparam logic [15:0] DB_LEAVE   = 16'h1001;
   localparam logic [31:0] MAC_PREFIX = 32'h0001_0001;

   // Result kinds
   localparam logic [2:0] KIND_QUEUED    = 3'd0;
   localparam logic [2:0] KIND_BUSY      = 3'd1;
   localparam logic [2:0] KIND_NO_DEST   = 3'd2;
   localparam logic [2:0] KIND_JOIN      = 3'd3;
   localparam logic [2:0] KIND_NO_ACTION = 3'd4;
   localparam logic [2:0] KIND_UNHANDLED = 3'd5;
   localparam logic [2:0] KIND_DONE      = 3'd6;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] node_id;
      logic [15:0] doorbell_info;
      logic [47:0] dest_mac;
      logic [6:0]  done_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] dest_node;
      logic [6:0]  ring_slot;
      logic [7:0]  in_flight;
      logic        queue_stopped;
      logic [6:0]  active_peers;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/peer_table_tx_ring_tracker.sv]
// Each input item is registered on transfer; its result is registered once the result register is free.
// Multicast fans out over the peer table, reading then checking each entry in turn from the lowest id.
// The next item is taken only once the last result is registered; the peer table memory has a
// separate read and write port, and every command reads it on transfer before any write back.
// Reset: synchronous, clears the peer valid bits, ring counters, flags and handshake state.
`default_nettype none

module peer_table_tx_ring_tracker (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire ptt_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output ptt_pkg::rsp_type     rsp_data
);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_EXEC     = 2'd1;
   localparam logic [1:0] ST_SCAN_RD  = 2'd2;
   localparam logic [1:0] ST_SCAN_CHK = 2'd3;

   typedef struct packed {
      logic known;
      logic active;
   } entry_type;

   // Peer table memory with per-entry valid bits
   entry_type                        tbl_mem [ptt_pkg::NODE_SLOTS];
   logic [ptt_pkg::NODE_SLOTS-1:0]   vld_ff;
   entry_type                        mem_q_ff;
   logic                             vld_q_ff;

   logic [1:0]                       state_ff, state_in;
   ptt_pkg::req_type                 item_ff, item_in;
   logic [ptt_pkg::COUNT_W-1:0]      active_count_ff, active_count_in;
   logic [ptt_pkg::FLIGHT_W-1:0]     outstanding_ff, outstanding_in;
   logic [ptt_pkg::SLOT_W-1:0]       write_slot_ff, write_slot_in;
   logic [ptt_pkg::SLOT_W-1:0]       retire_slot_ff, retire_slot_in;
   logic                             stopped_ff, stopped_in;
   logic [ptt_pkg::NODE_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [ptt_pkg::COUNT_W-1:0]      sent_ff, sent_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ptt_pkg::rsp_type                 rsp_data_ff;

   logic                             out_free;
   logic                             req_fire;
   logic                             rd_en;
   logic [ptt_pkg::NODE_W-1:0]       rd_addr;
   logic                             wr_en;
   logic [ptt_pkg::NODE_W-1:0]       wr_addr;
   entry_type                        wr_data;
   entry_type                        entry;

   logic                             id_in_table;
   logic [ptt_pkg::NODE_W-1:0]       id_addr;
   logic [15:0]                      uni_dst;
   logic                             uni_ok;
   logic                             multi;
   logic [ptt_pkg::COUNT_W-1:0]      need;
   logic                             room_bad;

   logic [ptt_pkg::FLIGHT_W-1:0]     q_flight;
   logic                             q_stop;
   logic [ptt_pkg::SLOT_W-1:0]       q_slot_next;

   logic [ptt_pkg::FLIGHT_W-1:0]     span;
   logic [ptt_pkg::FLIGHT_W-1:0]     steps;
   logic [ptt_pkg::FLIGHT_W-1:0]     retire_sum;
   logic [ptt_pkg::SLOT_W-1:0]       retire_next;
   logic [ptt_pkg::FLIGHT_W-1:0]     flight_after;

   logic                             emit;
   logic [2:0]                       emit_kind;
   logic [15:0]                      emit_node;
   logic [ptt_pkg::SLOT_W-1:0]       emit_slot;
   logic                             emit_last;
   ptt_pkg::rsp_type                 rsp_new;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Select the table read address: item lookup on transfer, else the scan pointer
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = scan_idx_ff;
      if (req_fire) begin
         rd_en = 1'b1;
         if (req_data.command == ptt_pkg::CMD_TRANSMIT) begin
            rd_addr = req_data.dest_mac[ptt_pkg::NODE_W-1:0];
         end else begin
            rd_addr = req_data.node_id[ptt_pkg::NODE_W-1:0];
         end
      end else if (state_ff == ST_SCAN_RD) begin
         rd_en = 1'b1;
      end
   end

   // Table read and write ports
   always_ff @(posedge clock) begin
      if (rd_en && (rd_addr < ptt_pkg::NODE_SLOTS)) begin
         mem_q_ff <= tbl_mem[rd_addr];
         vld_q_ff <= vld_ff[rd_addr];
      end
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
   end

   // An entry never written reads as unknown and inactive
   assign entry = vld_q_ff ? mem_q_ff : '0;

   // Decode the held item
   assign id_in_table = (item_ff.node_id < 16'(ptt_pkg::NODE_SLOTS));
   assign id_addr     = item_ff.node_id[ptt_pkg::NODE_W-1:0];
   assign uni_dst     = item_ff.dest_mac[15:0];
   assign uni_ok      = (item_ff.dest_mac[47:16] == ptt_pkg::MAC_PREFIX) &&
                        (uni_dst < 16'(ptt_pkg::NODE_SLOTS)) && entry.active;
   assign multi       = item_ff.dest_mac[40];
   assign need        = multi ? active_count_ff : ptt_pkg::COUNT_W'(1);
   assign room_bad    = ({1'b0, outstanding_ff} + {2'b00, need}) >
                        (ptt_pkg::FLIGHT_W+1)'(ptt_pkg::RING_SLOTS);

   // Ring bookkeeping for one queued frame
   assign q_flight    = outstanding_ff + ptt_pkg::FLIGHT_W'(1);
   assign q_stop      = (q_flight == ptt_pkg::FLIGHT_W'(ptt_pkg::RING_SLOTS)) ? 1'b1 : stopped_ff;
   assign q_slot_next = (write_slot_ff == ptt_pkg::SLOT_W'(ptt_pkg::RING_SLOTS-1)) ?
                        '0 : write_slot_ff + ptt_pkg::SLOT_W'(1);

   // Retire count: distance to the done slot, capped by what is outstanding
   always_comb begin
      if ({1'b0, item_ff.done_slot} >= ptt_pkg::FLIGHT_W'(ptt_pkg::RING_SLOTS)) begin
         span = outstanding_ff;
      end else if (item_ff.done_slot >= retire_slot_ff) begin
         span = {1'b0, item_ff.done_slot - retire_slot_ff};
      end else begin
         span = {1'b0, item_ff.done_slot} + ptt_pkg::FLIGHT_W'(ptt_pkg::RING_SLOTS)
                - {1'b0, retire_slot_ff};
      end
      steps        = (span < outstanding_ff) ? span : outstanding_ff;
      retire_sum   = {1'b0, retire_slot_ff} + steps;
      retire_next  = (retire_sum >= ptt_pkg::FLIGHT_W'(ptt_pkg::RING_SLOTS)) ?
                     ptt_pkg::SLOT_W'(retire_sum - ptt_pkg::FLIGHT_W'(ptt_pkg::RING_SLOTS)) :
                     retire_sum[ptt_pkg::SLOT_W-1:0];
      flight_after = outstanding_ff - steps;
   end

   // Sequencer: execute the held item, or walk the table for multicast
   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      active_count_in = active_count_ff;
      outstanding_in  = outstanding_ff;
      write_slot_in   = write_slot_ff;
      retire_slot_in  = retire_slot_ff;
      stopped_in      = stopped_ff;
      scan_idx_in     = scan_idx_ff;
      sent_in         = sent_ff;
      wr_en           = 1'b0;
      wr_addr         = id_addr;
      wr_data         = entry;
      emit            = 1'b0;
      emit_kind       = ptt_pkg::KIND_NO_ACTION;
      emit_node       = '0;
      emit_slot       = '0;
      emit_last       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
               emit     = 1'b1;
               unique case (item_ff.command)
                  ptt_pkg::CMD_REGISTER: begin
                     // Mark the peer known, keep its active bit
                     if (id_in_table) begin
                        wr_en   = 1'b1;
                        wr_data = '{known: 1'b1, active: entry.active};
                     end
                  end

                  ptt_pkg::CMD_DOORBELL: begin
                     priority if (item_ff.doorbell_info == ptt_pkg::DB_JOIN) begin
                        if (id_in_table && !entry.active) begin
                           if (entry.known) begin
                              wr_en           = 1'b1;
                              wr_data         = '{known: 1'b1, active: 1'b1};
                              active_count_in = active_count_ff + ptt_pkg::COUNT_W'(1);
                           end
                           emit_kind = ptt_pkg::KIND_JOIN;
                           emit_node = item_ff.node_id;
                        end
                     end else if (item_ff.doorbell_info == ptt_pkg::DB_LEAVE) begin
                        if (id_in_table && entry.active) begin
                           wr_en           = 1'b1;
                           wr_data         = '{known: entry.known, active: 1'b0};
                           active_count_in = active_count_ff - ptt_pkg::COUNT_W'(1);
                        end
                     end else begin
                        emit_kind = ptt_pkg::KIND_UNHANDLED;
                     end
                  end

                  ptt_pkg::CMD_TRANSMIT: begin
                     priority if (room_bad) begin
                        stopped_in = 1'b1;
                        emit_kind  = ptt_pkg::KIND_BUSY;
                     end else if (multi) begin
                        if (active_count_ff == '0) begin
                           emit_kind = ptt_pkg::KIND_NO_DEST;
                        end else begin
                           // Start the fan-out walk from the lowest id
                           emit        = 1'b0;
                           state_in    = ST_SCAN_RD;
                           scan_idx_in = '0;
                           sent_in     = '0;
                        end
                     end else if (uni_ok) begin
                        outstanding_in = q_flight;
                        stopped_in     = q_stop;
                        write_slot_in  = q_slot_next;
                        emit_kind      = ptt_pkg::KIND_QUEUED;
                        emit_node      = uni_dst;
                        emit_slot      = write_slot_ff;
                     end else begin
                        emit_kind = ptt_pkg::KIND_NO_DEST;
                     end
                  end

                  ptt_pkg::CMD_COMPLETE: begin
                     // Retire slots up to the reported one
                     retire_slot_in = retire_next;
                     outstanding_in = flight_after;
                     if (flight_after < ptt_pkg::FLIGHT_W'(ptt_pkg::RING_SLOTS)) begin
                        stopped_in = 1'b0;
                     end
                     emit_kind = ptt_pkg::KIND_DONE;
                     emit_slot = retire_next;
                  end

                  default: begin
                     emit_kind = ptt_pkg::KIND_NO_ACTION;
                  end
               endcase
            end
         end

         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end

         ST_SCAN_CHK: begin
            if (entry.active) begin
               // Queue one frame to this peer once the result register is free
               if (out_free) begin
                  emit           = 1'b1;
                  outstanding_in = q_flight;
                  stopped_in     = q_stop;
                  write_slot_in  = q_slot_next;
                  sent_in        = sent_ff + ptt_pkg::COUNT_W'(1);
                  emit_kind      = ptt_pkg::KIND_QUEUED;
                  emit_node      = 16'(scan_idx_ff);
                  emit_slot      = write_slot_ff;
                  emit_last      = (sent_in == active_count_ff);
                  if (emit_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     scan_idx_in = scan_idx_ff + ptt_pkg::NODE_W'(1);
                     state_in    = ST_SCAN_RD;
                  end
               end
            end else begin
               scan_idx_in = scan_idx_ff + ptt_pkg::NODE_W'(1);
               state_in    = ST_SCAN_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_new.kind          = emit_kind;
      rsp_new.dest_node     = emit_node;
      rsp_new.ring_slot     = emit_slot;
      rsp_new.in_flight     = outstanding_in;
      rsp_new.queue_stopped = stopped_in;
      rsp_new.active_peers  = active_count_in;
      rsp_new.last          = emit_last;

      // Hold a stalled result, drop one that was taken
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_count_ff <= '0;
         outstanding_ff  <= '0;
         write_slot_ff   <= '0;
         retire_slot_ff  <= '0;
         stopped_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         vld_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         active_count_ff <= active_count_in;
         outstanding_ff  <= outstanding_in;
         write_slot_ff   <= write_slot_in;
         retire_slot_ff  <= retire_slot_in;
         stopped_ff      <= stopped_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      scan_idx_ff <= scan_idx_in;
      sent_ff     <= sent_in;
      if (emit) begin
         rsp_data_ff <= rsp_new;
      end
   end

endmodule

`default_nettype wire

[rtl/ptt_checker.sv]
`default_nettype none

module ptt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire ptt_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire ptt_pkg::rsp_type rsp_data
);

   // No result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // In-flight count never exceeds the ring
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.in_flight <= ptt_pkg::FLIGHT_W'(ptt_pkg::RING_SLOTS))
      else $error("in-flight count beyond ring size");

   // A full ring always shows the queue stopped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.in_flight == ptt_pkg::FLIGHT_W'(ptt_pkg::RING_SLOTS))
      |-> rsp_data.queue_stopped)
      else $error("full ring without queue stopped");

   // A completion result is always the last result of its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == ptt_pkg::KIND_DONE) |-> rsp_data.last)
      else $error("completion result not last");

endmodule

bind peer_table_tx_ring_tracker ptt_checker u_ptt_checker (.*);

`default_nettype wire

[dv/peer_table_tx_ring_tracker_tb.sv]
`timescale 1ns / 1ps

module peer_table_tx_ring_tracker_tb;
   import ptt_pkg::*;

   localparam int GAP_MAX      = 14;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 110;
   localparam int CALM_ITEMS   = 30;
   localparam int DRAIN_CYCLES = 20;
   localparam int LIMIT_NS     = 10_000_000;
   localparam logic [47:0] MCAST_BIT = 48'h0100_0000_0000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Predicted peer table and ring state
   logic [NODE_SLOTS-1:0] known_bits;
   logic [NODE_SLOTS-1:0] active_bits;
   int      peer_count;
   int      ring_used;
   int      head_slot;
   int      tail_slot;
   logic    ring_stop;
   rsp_type ring_result_q[$];

   int mismatches = 0;
   int transfers = 0;
   int results_seen = 0;
   int kind_seen[8];
   int stall_pct = 20;
   int gap_pct = 20;
   int hold_left = 0;

   peer_table_tx_ring_tracker uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Snapshot the predicted counters into one result
   function automatic rsp_type make_result(logic [2:0] kind, int node, int slot);
      rsp_type r;
      r.kind          = kind;
      r.dest_node     = 16'(node);
      r.ring_slot     = 7'(slot);
      r.in_flight     = 8'(ring_used);
      r.queue_stopped = ring_stop;
      r.active_peers  = 7'(peer_count);
      r.last          = 1'b0;
      return r;
   endfunction

   // Claim the write slot for one frame
   function automatic rsp_type queue_frame(int node);
      int slot;
      slot = head_slot;
      ring_used++;
      if (ring_used == RING_SLOTS) ring_stop = 1'b1;
      head_slot = (head_slot + 1) % RING_SLOTS;
      return make_result(KIND_QUEUED, node, slot);
   endfunction

   // Update the predicted tables and ring for one transfer, queue its results
   task automatic predict_tracker(input req_type item);
      rsp_type                batch[$];
      rsp_type                r;
      logic [NODE_W-1:0]      idx;
      logic                   in_table;
      int                     need;
      int                     dst;
      int                     i;
      idx      = item.node_id[NODE_W-1:0];
      in_table = item.node_id < NODE_SLOTS;
      case (item.command)
         CMD_REGISTER: begin
            if (in_table) known_bits[idx] = 1'b1;
            batch.push_back(make_result(KIND_NO_ACTION, 0, 0));
         end
         CMD_DOORBELL: begin
            if (item.doorbell_info == DB_JOIN) begin
               if (in_table && !active_bits[idx]) begin
                  // an unknown peer still gets a reply but stays inactive
                  if (known_bits[idx]) begin
                     active_bits[idx] = 1'b1;
                     peer_count++;
                  end
                  batch.push_back(make_result(KIND_JOIN, int'(item.node_id), 0));
               end else begin
                  batch.push_back(make_result(KIND_NO_ACTION, 0, 0));
               end
            end else if (item.doorbell_info == DB_LEAVE) begin
               if (in_table && active_bits[idx]) begin
                  active_bits[idx] = 1'b0;
                  peer_count--;
               end
               batch.push_back(make_result(KIND_NO_ACTION, 0, 0));
            end else begin
               batch.push_back(make_result(KIND_UNHANDLED, 0, 0));
            end
         end
         CMD_TRANSMIT: begin
            need = item.dest_mac[40] ? peer_count : 1;
            if (ring_used + need > RING_SLOTS) begin
               ring_stop = 1'b1;
               batch.push_back(make_result(KIND_BUSY, 0, 0));
            end else if (item.dest_mac[40]) begin
               // fan out to active peers in ascending id order
               for (i = 0; i < NODE_SLOTS; i++)
                  if (active_bits[i]) batch.push_back(queue_frame(i));
               if (batch.size() == 0) batch.push_back(make_result(KIND_NO_DEST, 0, 0));
            end else begin
               dst = int'(item.dest_mac[15:0]);
               if (item.dest_mac[47:16] == MAC_PREFIX && dst < NODE_SLOTS && active_bits[dst])
                  batch.push_back(queue_frame(dst));
               else
                  batch.push_back(make_result(KIND_NO_DEST, 0, 0));
            end
         end
         default: begin
            // retire slots up to the reported one
            while (ring_used != 0 && tail_slot != int'(item.done_slot)) begin
               tail_slot = (tail_slot + 1) % RING_SLOTS;
               ring_used--;
            end
            if (ring_used < RING_SLOTS) ring_stop = 1'b0;
            batch.push_back(make_result(KIND_DONE, 0, tail_slot));
         end
      endcase
      foreach (batch[k]) begin
         r      = batch[k];
         r.last = (k == batch.size() - 1);
         ring_result_q.push_back(r);
      end
   endtask

   function automatic req_type make_item(logic [1:0] cmd, int id, logic [15:0] info,
                                         logic [47:0] mac, int done);
      req_type item;
      item.command       = cmd;
      item.node_id       = 16'(id);
      item.doorbell_info = info;
      item.dest_mac      = mac;
      item.done_slot     = 7'(done);
      return item;
   endfunction

   // Mostly well-formed traffic on a small peer pool, with some noise
   function automatic req_type random_item();
      req_type item;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 20)      item.command = CMD_REGISTER;
      else if (pick < 50) item.command = CMD_DOORBELL;
      else if (pick < 85) item.command = CMD_TRANSMIT;
      else                item.command = CMD_COMPLETE;
      pick = $urandom_range(99);
      if (pick < 10)      item.node_id = 16'($urandom);
      else if (pick < 60) item.node_id = 16'($urandom_range(0, 15));
      else                item.node_id = 16'($urandom_range(0, NODE_SLOTS - 1));
      pick = $urandom_range(99);
      if (pick < 40)      item.doorbell_info = DB_JOIN;
      else if (pick < 75) item.doorbell_info = DB_LEAVE;
      else                item.doorbell_info = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 35)
         item.dest_mac = {16'($urandom), 32'($urandom)} | MCAST_BIT;
      else if (pick < 85)
         item.dest_mac = {MAC_PREFIX, 16'($urandom_range(0, (pick < 60) ? 15 : NODE_SLOTS - 1))};
      else
         item.dest_mac = {16'($urandom), 32'($urandom)};
      if ($urandom_range(99) < 60)
         item.done_slot = 7'((tail_slot + $urandom_range(0, ring_used)) % RING_SLOTS);
      else
         item.done_slot = 7'($urandom);
      return item;
   endfunction

   // Offer one item and hold it until the transfer happens
   task automatic send_item(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_tracker(item);
      transfers++;
   endtask

   // Drop valid for a random burst now and then
   task automatic sender_gap();
      int n;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         n = $urandom_range(1, GAP_MAX);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (ring_result_q.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (ring_result_q.size() == 0) begin
            report_mismatch("unexpected result, kind", 16'(rsp_data.kind), 16'd0);
         end else begin
            want = ring_result_q.pop_front();
            kind_seen[want.kind]++;
            check_field("kind", 16'(rsp_data.kind), 16'(want.kind));
            check_field("dest_node", rsp_data.dest_node, want.dest_node);
            check_field("ring_slot", 16'(rsp_data.ring_slot), 16'(want.ring_slot));
            check_field("in_flight", 16'(rsp_data.in_flight), 16'(want.in_flight));
            check_field("queue_stopped", 16'(rsp_data.queue_stopped),
                        16'(want.queue_stopped));
            check_field("active_peers", 16'(rsp_data.active_peers), 16'(want.active_peers));
            check_field("last", 16'(rsp_data.last), 16'(want.last));
         end
      end
   end

   // Result side stall: random bursts, plus a long hold-off on request
   initial begin
      int burst;
      burst = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else begin
            rsp_stall <= 1'b0;
            if (stall_pct != 0 && $urandom_range(99) < stall_pct)
               burst = $urandom_range(1, GAP_MAX);
         end
      end
   end

   // Table and doorbell corner cases, unicast sends, completions and an empty multicast
   task automatic test_directed();
      send_item(make_item(CMD_REGISTER, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 7'h7F));
      send_item(make_item(CMD_REGISTER, 0, 0, 0, 0));
      sender_gap();
      send_item(make_item(CMD_REGISTER, NODE_SLOTS - 1, 0, 0, 0));
      send_item(make_item(CMD_REGISTER, 5, 0, 0, 0));
      send_item(make_item(CMD_DOORBELL, 70, DB_JOIN, 0, 0));
      // unknown peer: reply sent, peer stays inactive
      send_item(make_item(CMD_DOORBELL, 9, DB_JOIN, 0, 0));
      sender_gap();
      send_item(make_item(CMD_DOORBELL, 0, DB_JOIN, 0, 0));
      send_item(make_item(CMD_DOORBELL, NODE_SLOTS - 1, DB_JOIN, 0, 0));
      send_item(make_item(CMD_DOORBELL, 5, DB_JOIN, 0, 0));
      send_item(make_item(CMD_DOORBELL, 5, DB_JOIN, 0, 0));
      send_item(make_item(CMD_DOORBELL, 0, 16'hFFFF, 0, 0));
      send_item(make_item(CMD_DOORBELL, 16'hFFFF, 16'h0000, 0, 0));
      sender_gap();
      // unicast: good, inactive peer, bad prefix, id beyond the table
      send_item(make_item(CMD_TRANSMIT, 0, 0, {MAC_PREFIX, 16'd5}, 0));
      send_item(make_item(CMD_TRANSMIT, 0, 0, {MAC_PREFIX, 16'd9}, 0));
      send_item(make_item(CMD_TRANSMIT, 0, 0, 48'hFE00_0001_0005, 0));
      send_item(make_item(CMD_TRANSMIT, 0, 0, {MAC_PREFIX, 16'hFFFF}, 0));
      send_item(make_item(CMD_TRANSMIT, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 7'h7F));
      sender_gap();
      send_item(make_item(CMD_COMPLETE, 0, 0, 0, 2));
      send_item(make_item(CMD_DOORBELL, NODE_SLOTS - 1, DB_LEAVE, 0, 0));
      send_item(make_item(CMD_DOORBELL, 9, DB_LEAVE, 0, 0));
      send_item(make_item(CMD_DOORBELL, 16'hFFFF, DB_LEAVE, 0, 0));
      send_item(make_item(CMD_COMPLETE, 0, 0, 0, 7'h7F));
      send_item(make_item(CMD_COMPLETE, 0, 0, 0, 0));
      send_item(make_item(CMD_DOORBELL, 0, DB_LEAVE, 0, 0));
      send_item(make_item(CMD_DOORBELL, 5, DB_LEAVE, 0, 0));
      // multicast with nobody active
      send_item(make_item(CMD_TRANSMIT, 0, 0, MCAST_BIT, 0));
      sender_gap();
   endtask

   // Fill the peer table, then drive the ring to full, busy and back
   task automatic test_ring_limits();
      int start;
      int stride;
      int k;
      start  = $urandom_range(0, NODE_SLOTS - 1);
      stride = 2 * $urandom_range(0, NODE_SLOTS / 2 - 1) + 1;
      // visit ids in a shuffled order: odd stride over a power of two
      for (k = 0; k < NODE_SLOTS; k++) begin
         send_item(make_item(CMD_REGISTER, (start + k * stride) % NODE_SLOTS, 0, 0, 0));
         sender_gap();
      end
      for (k = 0; k < NODE_SLOTS; k++) begin
         send_item(make_item(CMD_DOORBELL, (start + k * stride) % NODE_SLOTS, DB_JOIN, 0, 0));
         sender_gap();
      end
      send_item(make_item(CMD_COMPLETE, 0, 0, 0, head_slot));
      send_item(make_item(CMD_TRANSMIT, 0, 0, MCAST_BIT | 48'($urandom), 0));
      sender_gap();
      send_item(make_item(CMD_TRANSMIT, 0, 0, MCAST_BIT, 0));
      send_item(make_item(CMD_TRANSMIT, 0, 0, {MAC_PREFIX, 16'(start)}, 0));
      // full ring: completion at the retire slot frees nothing
      send_item(make_item(CMD_COMPLETE, 0, 0, 0, tail_slot));
      send_item(make_item(CMD_COMPLETE, 0, 0, 0, (tail_slot + 1) % RING_SLOTS));
      send_item(make_item(CMD_TRANSMIT, 0, 0, MCAST_BIT, 0));
      sender_gap();
      send_item(make_item(CMD_COMPLETE, 0, 0, 0, head_slot));
   endtask

   // Stall the result side long enough to back up the input
   task automatic test_backpressure();
      int k;
      hold_left = HOLD_CYCLES;
      for (k = 0; k < 8; k++) send_item(random_item());
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      int k;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         // switch idling density every few dozen transfers, none at the tail
         if (k >= RANDOM_ITEMS - CALM_ITEMS) begin
            stall_pct = 0;
            gap_pct   = 0;
         end else if (k % 40 == 0) begin
            stall_pct = 15 * $urandom_range(0, 3);
            gap_pct   = 15 * $urandom_range(0, 3);
         end
         send_item(random_item());
         sender_gap();
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      known_bits  = '0;
      active_bits = '0;
      peer_count  = 0;
      ring_used   = 0;
      head_slot   = 0;
      tail_slot   = 0;
      ring_stop   = 1'b0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_ring_limits();
      test_backpressure();
      test_random_traffic();

      // let everything drain, then watch for stray results
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d input transfers and %0d results: %0d queued frames, %0d busy,",
               transfers, results_seen, kind_seen[KIND_QUEUED], kind_seen[KIND_BUSY]);
      $display("%0d no destination, %0d join replies, %0d completions, full table and ring.",
               kind_seen[KIND_NO_DEST], kind_seen[KIND_JOIN], kind_seen[KIND_DONE]);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_NS);
      $display("Timeout with %0d results still pending", ring_result_q.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
